// ===== rtl/linear_arena_allocator_top_macros.svh =====
// Assertion macros shared by the checker of the arena allocator.
`ifndef LINEAR_ARENA_ALLOCATOR_TOP_MACROS_SVH
`define LINEAR_ARENA_ALLOCATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LAA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arena allocator check failed");

// The consequent must hold in the cycle after the antecedent.
`define LAA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arena allocator check failed");

`endif

// ===== rtl/laa_pkg.sv =====
// Package with widths, codes and shared types of the arena allocator.
package laa_pkg;

    localparam int ADDR_W          = 48;
    localparam int SIZE_W          = 32;
    localparam int ACT_W           = 2;
    localparam int AMT_W           = SIZE_W + 1;
    localparam int SUM_W           = ADDR_W + 2;
    localparam int MOD_STEPS       = ADDR_W / 2;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_ADDR_W      = 4;
    localparam int DEF_OFFSET_BITS = 32;
    localparam int DEF_ALIGN_BITS  = 17;

    // Register select, taken from the doubleword bit of the address.
    localparam logic REG_BASE = 1'b0;
    localparam logic REG_CAP  = 1'b1;

    typedef enum logic [ACT_W-1:0] {
        ACT_REALLOC  = 2'd0,
        ACT_REWIND   = 2'd1,
        ACT_FREE_ALL = 2'd2,
        ACT_READ     = 2'd3
    } t_action;

    typedef struct packed {
        logic [ADDR_W-1:0] base_address;
        logic [SIZE_W-1:0] capacity;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic start_old;
        logic start_end;
        logic take_old;
        logic take_end;
        logic plan;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_old;
        logic need_end;
        logic rem_done;
    } t_sts;

endpackage

// ===== rtl/laa_ifs.sv =====
// Request and response channel interfaces of the arena allocator.
interface laa_req_if #(
    parameter int ALIGN_BITS = laa_pkg::DEF_ALIGN_BITS
);
    import laa_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ACT_W-1:0]      action;
    logic [ADDR_W-1:0]     old_address;
    logic [SIZE_W-1:0]     old_size;
    logic [SIZE_W-1:0]     new_size;
    logic [ALIGN_BITS-1:0] alignment;
    logic [SIZE_W-1:0]     mark;

    modport source (
        output valid, action, old_address, old_size, new_size, alignment, mark,
        input  ready
    );
    modport sink (
        input  valid, action, old_address, old_size, new_size, alignment, mark,
        output ready
    );
endinterface

interface laa_rsp_if #(
    parameter int OFFSET_BITS = laa_pkg::DEF_OFFSET_BITS
);
    import laa_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   ok;
    logic [ADDR_W-1:0]      new_address;
    logic                   copy_needed;
    logic [SIZE_W-1:0]      copy_length;
    logic [OFFSET_BITS-1:0] cursor_now;

    modport source (
        output valid, ok, new_address, copy_needed, copy_length, cursor_now,
        input  ready
    );
    modport sink (
        input  valid, ok, new_address, copy_needed, copy_length, cursor_now,
        output ready
    );
endinterface

// ===== rtl/laa_regs.sv =====
// APB configuration registers of the arena allocator.
module laa_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [laa_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [laa_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [laa_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output laa_pkg::t_cfg                  o_cfg
);
    import laa_pkg::*;

    logic [ADDR_W-1:0] r_base;
    logic [SIZE_W-1:0] r_cap;
    logic              w_sel;
    logic              w_wr;

    // The registers sit on doubleword boundaries, so bit 3 selects them.
    assign w_sel  = paddr[3];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    // Write in the access phase of a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_cap  <= '0;
        end else if (w_wr) begin
            unique case (w_sel)
                REG_BASE: r_base <= pwdata[ADDR_W-1:0];
                REG_CAP:  r_cap  <= pwdata[SIZE_W-1:0];
                default:  r_base <= r_base;
            endcase
        end
    end

    // Read data follows the address.
    always_comb begin
        unique case (w_sel)
            REG_BASE: prdata = CFG_DATA_W'(r_base);
            REG_CAP:  prdata = CFG_DATA_W'(r_cap);
            default:  prdata = '0;
        endcase
    end

    assign o_cfg.base_address = r_base;
    assign o_cfg.capacity     = r_cap;

endmodule

// ===== rtl/laa_rem.sv =====
// Iterative remainder unit: address modulo alignment, two bits per cycle.
module laa_rem #(
    parameter int ALIGN_BITS = laa_pkg::DEF_ALIGN_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [laa_pkg::ADDR_W-1:0] i_dividend,
    input  logic [ALIGN_BITS-1:0]      i_divisor,
    output logic [ALIGN_BITS-1:0]      o_rem,
    output logic                       o_done
);
    import laa_pkg::*;

    localparam int CNT_W = $clog2(MOD_STEPS + 1);

    logic [CNT_W-1:0]      r_cnt;
    logic [ADDR_W-1:0]     r_dvd;
    logic [ALIGN_BITS-1:0] r_rem;
    logic [ALIGN_BITS-1:0] w_rem_hi;
    logic [ALIGN_BITS-1:0] w_rem_lo;

    // One restoring step: shift in a bit, subtract the divisor if it fits.
    function automatic logic [ALIGN_BITS-1:0] f_step(
        input logic [ALIGN_BITS-1:0] rem,
        input logic                  bit_in,
        input logic [ALIGN_BITS-1:0] div
    );
        logic [ALIGN_BITS:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, div}) begin
            t = t - {1'b0, div};
        end
        return t[ALIGN_BITS-1:0];
    endfunction

    assign w_rem_hi = f_step(r_rem, r_dvd[ADDR_W-1], i_divisor);
    assign w_rem_lo = f_step(w_rem_hi, r_dvd[ADDR_W-2], i_divisor);

    // Step counter; control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(MOD_STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Dividend shift register and partial remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[ADDR_W-3:0], 2'b00};
            r_rem <= w_rem_lo;
        end
    end

    assign o_rem  = r_rem;
    assign o_done = (r_cnt == '0);

endmodule

// ===== rtl/laa_dp.sv =====
// Datapath of the arena allocator: operands, cursor, planning and result.
module laa_dp #(
    parameter int OFFSET_BITS = laa_pkg::DEF_OFFSET_BITS,
    parameter int ALIGN_BITS  = laa_pkg::DEF_ALIGN_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  laa_pkg::t_cfg              i_cfg,
    input  laa_pkg::t_cmd              i_cmd,
    output laa_pkg::t_sts              o_sts,
    input  logic [laa_pkg::ACT_W-1:0]  i_action,
    input  logic [laa_pkg::ADDR_W-1:0] i_old_address,
    input  logic [laa_pkg::SIZE_W-1:0] i_old_size,
    input  logic [laa_pkg::SIZE_W-1:0] i_new_size,
    input  logic [ALIGN_BITS-1:0]      i_alignment,
    input  logic [laa_pkg::SIZE_W-1:0] i_mark,
    output logic                       o_ok,
    output logic [laa_pkg::ADDR_W-1:0] o_new_address,
    output logic                       o_copy_needed,
    output logic [laa_pkg::SIZE_W-1:0] o_copy_length,
    output logic [OFFSET_BITS-1:0]     o_cursor_now
);
    import laa_pkg::*;

    localparam logic [OFFSET_BITS-1:0] OFS_MAX = '1;

    typedef enum logic [2:0] {
        K_KEEP = 3'd0,
        K_PULL = 3'd1,
        K_BUMP = 3'd2,
        K_SET  = 3'd3,
        K_ZERO = 3'd4
    } t_kind;

    // Latched operands.
    t_action               r_action;
    logic [ADDR_W-1:0]     r_old_addr;
    logic [SIZE_W-1:0]     r_old_size;
    logic [SIZE_W-1:0]     r_new_size;
    logic [ALIGN_BITS-1:0] r_align;
    logic [SIZE_W-1:0]     r_mark;
    logic [ADDR_W-1:0]     r_end;
    logic [ADDR_W-1:0]     r_top;
    logic [ALIGN_BITS-1:0] r_rem_old;
    logic [ALIGN_BITS-1:0] r_rem_end;

    // Plan of the cursor update.
    t_kind                  r_kind,   n_kind;
    logic [AMT_W-1:0]       r_amount, n_amount;
    logic [ADDR_W-1:0]      r_addr,   n_addr;
    logic                   r_copy,   n_copy;
    logic [SIZE_W-1:0]      r_clen,   n_clen;
    logic [OFFSET_BITS-1:0] r_limit,  n_limit;

    // Cursor and result.
    logic [OFFSET_BITS-1:0] r_cursor, n_cursor;
    logic                   r_ok,     n_ok;
    logic [ADDR_W-1:0]      r_res_addr, n_res_addr;
    logic                   r_res_copy, n_res_copy;
    logic [SIZE_W-1:0]      r_res_clen, n_res_clen;

    logic [ALIGN_BITS-1:0] w_rem;
    logic                  w_rem_done;
    logic [ADDR_W-1:0]     w_dividend;
    logic                  w_is_last;
    logic [ALIGN_BITS-1:0] w_pad;
    logic [SUM_W-1:0]      w_sum;

    // Capture the request at its transfer; zero alignment means one.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action   <= t_action'(i_action);
            r_old_addr <= i_old_address;
            r_old_size <= i_old_size;
            r_new_size <= i_new_size;
            r_align    <= (i_alignment == '0) ? ALIGN_BITS'(1) : i_alignment;
            r_mark     <= i_mark;
            r_end      <= i_cfg.base_address + ADDR_W'(r_cursor);
            r_top      <= i_old_address + ADDR_W'(i_old_size);
        end
    end

    assign o_sts.need_end = (r_action == ACT_REALLOC) && (r_new_size != '0);
    assign o_sts.need_old = o_sts.need_end && (r_old_size != '0);
    assign o_sts.rem_done = w_rem_done;

    // Shared remainder unit for the old block and the arena end.
    assign w_dividend = i_cmd.start_end ? r_end : r_old_addr;

    laa_rem #(
        .ALIGN_BITS (ALIGN_BITS)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_old || i_cmd.start_end),
        .i_dividend (w_dividend),
        .i_divisor  (r_align),
        .o_rem      (w_rem),
        .o_done     (w_rem_done)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_old) begin
            r_rem_old <= w_rem;
        end
        if (i_cmd.take_end) begin
            r_rem_end <= w_rem;
        end
    end

    // Plan: classify the request and form the amount and candidate address.
    assign w_is_last = (r_old_addr != '0) && (r_top == r_end);
    assign w_pad     = (r_rem_end != '0) ? (r_align - r_rem_end) : '0;

    always_comb begin
        n_kind   = K_KEEP;
        n_amount = '0;
        n_addr   = '0;
        n_copy   = 1'b0;
        n_clen   = '0;
        n_limit  = (SUM_W'(i_cfg.capacity) < SUM_W'(OFS_MAX)) ?
                   OFFSET_BITS'(i_cfg.capacity) : OFS_MAX;
        unique case (r_action)
            ACT_REALLOC: begin
                if (r_new_size == '0) begin
                    // Free: reclaim only the last block.
                    n_kind   = w_is_last ? K_PULL : K_KEEP;
                    n_amount = AMT_W'(r_old_size);
                end else if (r_old_size == '0 || r_rem_old != '0) begin
                    // Fresh allocation, with a copy when the old block is misaligned.
                    n_kind   = K_BUMP;
                    n_amount = AMT_W'(r_new_size) + AMT_W'(w_pad);
                    n_addr   = r_end + ADDR_W'(w_pad);
                    n_copy   = (r_old_size != '0);
                    n_clen   = (r_old_size == '0) ? '0 :
                               ((r_old_size < r_new_size) ? r_old_size : r_new_size);
                end else if (w_is_last) begin
                    // Resize the last block in place.
                    n_addr = r_old_addr;
                    if (r_new_size <= r_old_size) begin
                        n_kind   = K_PULL;
                        n_amount = AMT_W'(r_old_size - r_new_size);
                    end else begin
                        n_kind   = K_BUMP;
                        n_amount = AMT_W'(r_new_size - r_old_size);
                    end
                end else if (r_new_size <= r_old_size) begin
                    n_addr = r_old_addr;
                end else begin
                    // Grow elsewhere and copy the whole old block.
                    n_kind   = K_BUMP;
                    n_amount = AMT_W'(r_new_size) + AMT_W'(w_pad);
                    n_addr   = r_end + ADDR_W'(w_pad);
                    n_copy   = 1'b1;
                    n_clen   = r_old_size;
                end
            end
            ACT_REWIND: begin
                n_kind   = K_SET;
                n_amount = AMT_W'(r_mark);
            end
            ACT_FREE_ALL: n_kind = K_ZERO;
            ACT_READ:     n_kind = K_KEEP;
            default:      n_kind = K_KEEP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.plan) begin
            r_kind   <= n_kind;
            r_amount <= n_amount;
            r_addr   <= n_addr;
            r_copy   <= n_copy;
            r_clen   <= n_clen;
            r_limit  <= n_limit;
        end
    end

    // Finish: check the limit and form the new cursor and the result.
    assign w_sum = SUM_W'(r_cursor) + SUM_W'(r_amount);

    always_comb begin
        n_cursor   = r_cursor;
        n_ok       = 1'b1;
        n_res_addr = r_addr;
        n_res_copy = r_copy;
        n_res_clen = r_clen;
        unique case (r_kind)
            K_KEEP: n_cursor = r_cursor;
            K_PULL: begin
                n_cursor = (SUM_W'(r_amount) > SUM_W'(r_cursor)) ? '0 :
                           (r_cursor - OFFSET_BITS'(r_amount));
            end
            K_BUMP: begin
                if (w_sum <= SUM_W'(r_limit)) begin
                    n_cursor = OFFSET_BITS'(w_sum);
                end else begin
                    n_ok       = 1'b0;
                    n_res_addr = '0;
                    n_res_copy = 1'b0;
                    n_res_clen = '0;
                end
            end
            K_SET: begin
                if (SUM_W'(r_amount) <= SUM_W'(r_limit)) begin
                    n_cursor = OFFSET_BITS'(r_amount);
                end else begin
                    n_ok = 1'b0;
                end
            end
            K_ZERO:  n_cursor = '0;
            default: n_cursor = r_cursor;
        endcase
    end

    // The cursor is state and resets to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
        end else if (i_cmd.commit) begin
            r_cursor <= n_cursor;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_ok       <= n_ok;
            r_res_addr <= n_res_addr;
            r_res_copy <= n_res_copy;
            r_res_clen <= n_res_clen;
        end
    end

    assign o_ok          = r_ok;
    assign o_new_address = r_res_addr;
    assign o_copy_needed = r_res_copy;
    assign o_copy_length = r_res_clen;
    assign o_cursor_now  = r_cursor;

endmodule

// ===== rtl/laa_ctrl.sv =====
// Controller state machine of the arena allocator.
module laa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  laa_pkg::t_sts i_sts,
    output laa_pkg::t_cmd o_cmd
);
    import laa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE    = 3'd0,
        S_SETUP   = 3'd1,
        S_MOD_OLD = 3'd2,
        S_MOD_END = 3'd3,
        S_PLAN    = 3'd4,
        S_FINISH  = 3'd5
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                if (i_sts.need_old) begin
                    o_cmd.start_old = 1'b1;
                    n_state         = S_MOD_OLD;
                end else if (i_sts.need_end) begin
                    o_cmd.start_end = 1'b1;
                    n_state         = S_MOD_END;
                end else begin
                    n_state = S_PLAN;
                end
            end
            S_MOD_OLD: begin
                if (i_sts.rem_done) begin
                    o_cmd.take_old  = 1'b1;
                    o_cmd.start_end = 1'b1;
                    n_state         = S_MOD_END;
                end
            end
            S_MOD_END: begin
                if (i_sts.rem_done) begin
                    o_cmd.take_end = 1'b1;
                    n_state        = S_PLAN;
                end
            end
            S_PLAN: begin
                o_cmd.plan = 1'b1;
                n_state    = S_FINISH;
            end
            S_FINISH: begin
                // Hold the finished item until the output register is free.
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/linear_arena_allocator_top.sv =====
// Top level of the bump-pointer arena allocator.
// One request is in work at a time, and each gives exactly one response. A
// reallocation with a nonzero new size passes through the shared remainder
// unit, which takes old address modulo alignment (when there is an existing
// block) and arena end modulo alignment in turn at two bits per cycle over
// the 48-bit address; a free, rewind, free-all or cursor read skips it. A new
// request is taken while the previous response still waits in the output
// register. The user is to write the base address and capacity over APB at
// byte addresses 0 and 8 only while the block is idle; the block itself does
// not enforce this.
module linear_arena_allocator_top #(
    parameter int OFFSET_BITS = laa_pkg::DEF_OFFSET_BITS,
    parameter int ALIGN_BITS  = laa_pkg::DEF_ALIGN_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    laa_req_if.sink                        i_req,
    laa_rsp_if.source                      o_rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [laa_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [laa_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [laa_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import laa_pkg::*;

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    // Configuration registers.
    laa_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Sequencing of one request.
    laa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Arithmetic, cursor and response payload.
    laa_dp #(
        .OFFSET_BITS (OFFSET_BITS),
        .ALIGN_BITS  (ALIGN_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_action      (i_req.action),
        .i_old_address (i_req.old_address),
        .i_old_size    (i_req.old_size),
        .i_new_size    (i_req.new_size),
        .i_alignment   (i_req.alignment),
        .i_mark        (i_req.mark),
        .o_ok          (o_rsp.ok),
        .o_new_address (o_rsp.new_address),
        .o_copy_needed (o_rsp.copy_needed),
        .o_copy_length (o_rsp.copy_length),
        .o_cursor_now  (o_rsp.cursor_now)
    );

endmodule

// ===== rtl/laa_checker.sv =====
// Port-level checker of the arena allocator and its bind to the top level.
`include "linear_arena_allocator_top_macros.svh"

module laa_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_req_valid,
    input logic                       i_req_ready,
    input logic                       i_rsp_valid,
    input logic                       i_rsp_ready,
    input logic                       i_rsp_ok,
    input logic [laa_pkg::ADDR_W-1:0] i_rsp_new_address,
    input logic                       i_rsp_copy_needed,
    input logic [laa_pkg::SIZE_W-1:0] i_rsp_copy_length
);
    import laa_pkg::*;

    logic w_fail_clean;

    // A null block with no copy and no copy length.
    assign w_fail_clean = (i_rsp_new_address == '0) && !i_rsp_copy_needed &&
                          (i_rsp_copy_length == '0);

    // A response that is not taken stays offered.
    `LAA_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid)

    // Only one request is in work: no second transfer right after one.
    `LAA_ASSERT_NEXT(a_one_in_work, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)

    // A failed request returns a null block and no copy.
    `LAA_ASSERT_SAME(a_fail_clean, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ok, w_fail_clean)

    // A copy length is given only with a copy request.
    `LAA_ASSERT_SAME(a_copy_len, i_clk, i_rst_n, i_rsp_valid && !i_rsp_copy_needed, i_rsp_copy_length == '0)

endmodule

bind linear_arena_allocator_top laa_checker u_laa_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_ok          (o_rsp.ok),
    .i_rsp_new_address (o_rsp.new_address),
    .i_rsp_copy_needed (o_rsp.copy_needed),
    .i_rsp_copy_length (o_rsp.copy_length)
);

// ===== tb/sv/laa_response_check.sv =====
// Response checker of the arena allocator: predicts each response and compares it.
module laa_response_check
    import laa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    laa_req_if                    req_mon,
    laa_rsp_if                    rsp_mon,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OFFSET_W = DEF_OFFSET_BITS;
    localparam int ALIGN_W  = DEF_ALIGN_BITS;
    localparam logic [63:0] ADDR_MASK  = (64'd1 << ADDR_W) - 64'd1;
    localparam logic [63:0] OFFSET_MAX = (64'd1 << OFFSET_W) - 64'd1;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                ok;
        logic [ADDR_W-1:0]   new_address;
        logic                copy_needed;
        logic [SIZE_W-1:0]   copy_length;
        logic [OFFSET_W-1:0] cursor_now;
    } t_alloc_rsp;

    // Shadow copy of the allocator state and its registers.
    logic [OFFSET_W-1:0] cursor_q;
    logic [ADDR_W-1:0]   base_q;
    logic [SIZE_W-1:0]   cap_q;

    t_alloc_rsp expected_rsp_q[$];
    int         mismatch_count = 0;

    function automatic logic [63:0] cursor_limit();
        return (64'(cap_q) < OFFSET_MAX) ? 64'(cap_q) : OFFSET_MAX;
    endfunction

    function automatic logic [ADDR_W-1:0] arena_top();
        return base_q + ADDR_W'(cursor_q);
    endfunction

    // Bumps the cursor past padding and size; the cursor is untouched when space runs out.
    function automatic bit bump(input logic [63:0] size, input logic [63:0] align,
                                output logic [63:0] addr);
        logic [63:0] top;
        logic [63:0] rem;
        logic [63:0] pad;
        logic [63:0] amount;
        addr   = 64'd0;
        top    = 64'(arena_top());
        rem    = top % align;
        pad    = (rem != 64'd0) ? align - rem : 64'd0;
        amount = size + pad;
        if (64'(cursor_q) + amount > cursor_limit()) begin
            return 1'b0;
        end
        addr     = (top + pad) & ADDR_MASK;
        cursor_q = OFFSET_W'(64'(cursor_q) + amount);
        return 1'b1;
    endfunction

    function automatic bit is_last_block(input logic [ADDR_W-1:0] addr,
                                         input logic [SIZE_W-1:0] size);
        logic [ADDR_W-1:0] block_end;
        if (addr == '0) begin
            return 1'b0;
        end
        block_end = addr + ADDR_W'(size);
        return block_end == arena_top();
    endfunction

    // Moves the cursor back, stopping at zero.
    function automatic void pull_back(input logic [63:0] amount);
        cursor_q = (amount > 64'(cursor_q)) ? '0 : OFFSET_W'(64'(cursor_q) - amount);
    endfunction

    function automatic t_alloc_rsp predict_allocation(
        input t_action           act,
        input logic [ADDR_W-1:0] old_addr,
        input logic [SIZE_W-1:0] old_size,
        input logic [SIZE_W-1:0] new_size,
        input logic [ALIGN_W-1:0] align_in,
        input logic [SIZE_W-1:0] mark
    );
        t_alloc_rsp  rsp;
        logic [63:0] align;
        logic [63:0] placed;
        logic [63:0] scratch;
        bit          granted;
        rsp     = '0;
        rsp.ok  = 1'b1;
        granted = 1'b1;
        placed  = 64'd0;
        align   = (align_in == '0) ? 64'd1 : 64'(align_in);
        case (act)
            ACT_REALLOC: begin
                if (new_size == '0) begin
                    // Free: only the most recent block gives its space back.
                    if (is_last_block(old_addr, old_size)) begin
                        pull_back(64'(old_size));
                    end
                end else if (old_size == '0) begin
                    granted = bump(64'(new_size), align, placed);
                end else if (64'(old_addr) % align != 64'd0) begin
                    // The old block breaks the new alignment, so it moves.
                    granted = bump(64'(new_size), align, placed);
                    if (granted) begin
                        rsp.copy_needed = 1'b1;
                        rsp.copy_length = (old_size < new_size) ? old_size : new_size;
                    end
                end else if (is_last_block(old_addr, old_size)) begin
                    if (new_size <= old_size) begin
                        pull_back(64'(old_size - new_size));
                        placed = 64'(old_addr);
                    end else begin
                        granted = bump(64'(new_size - old_size), 64'd1, scratch);
                        if (granted) begin
                            placed = 64'(old_addr);
                        end
                    end
                end else if (new_size <= old_size) begin
                    placed = 64'(old_addr);
                end else begin
                    granted = bump(64'(new_size), align, placed);
                    if (granted) begin
                        rsp.copy_needed = 1'b1;
                        rsp.copy_length = old_size;
                    end
                end
                if (!granted) begin
                    placed          = 64'd0;
                    rsp.copy_needed = 1'b0;
                    rsp.copy_length = '0;
                end
                rsp.ok = granted;
            end
            ACT_REWIND: begin
                if (64'(mark) <= cursor_limit()) begin
                    cursor_q = OFFSET_W'(mark);
                end else begin
                    rsp.ok = 1'b0;
                end
            end
            ACT_FREE_ALL: begin
                cursor_q = '0;
            end
            default: begin
            end
        endcase
        rsp.new_address = placed[ADDR_W-1:0];
        rsp.cursor_now  = cursor_q;
        return rsp;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
        end
    endtask

    // Each clock edge: retire a response transfer, predict a request transfer, track writes.
    always @(posedge i_clk) begin
        t_alloc_rsp got;
        t_alloc_rsp want;
        if (!i_rst_n) begin
            cursor_q = '0;
            base_q   = '0;
            cap_q    = '0;
            expected_rsp_q.delete();
        end else begin
            if (rsp_mon.valid && rsp_mon.ready) begin
                got.ok          = rsp_mon.ok;
                got.new_address = rsp_mon.new_address;
                got.copy_needed = rsp_mon.copy_needed;
                got.copy_length = rsp_mon.copy_length;
                got.cursor_now  = rsp_mon.cursor_now;
                if (expected_rsp_q.size() == 0) begin
                    note_mismatch("response with none outstanding, cursor", 64'd0,
                                  64'(got.cursor_now));
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (got.ok !== want.ok) begin
                        note_mismatch("ok", 64'(want.ok), 64'(got.ok));
                    end
                    if (got.new_address !== want.new_address) begin
                        note_mismatch("new_address", 64'(want.new_address),
                                      64'(got.new_address));
                    end
                    if (got.copy_needed !== want.copy_needed) begin
                        note_mismatch("copy_needed", 64'(want.copy_needed),
                                      64'(got.copy_needed));
                    end
                    if (got.copy_length !== want.copy_length) begin
                        note_mismatch("copy_length", 64'(want.copy_length),
                                      64'(got.copy_length));
                    end
                    if (got.cursor_now !== want.cursor_now) begin
                        note_mismatch("cursor_now", 64'(want.cursor_now),
                                      64'(got.cursor_now));
                    end
                end
            end
            if (req_mon.valid && req_mon.ready) begin
                expected_rsp_q.push_back(predict_allocation(
                    t_action'(req_mon.action), req_mon.old_address, req_mon.old_size,
                    req_mon.new_size, req_mon.alignment, req_mon.mark));
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr[3] == REG_CAP) begin
                    cap_q = pwdata[SIZE_W-1:0];
                end else begin
                    base_q = pwdata[ADDR_W-1:0];
                end
            end
        end
        o_pending    <= expected_rsp_q.size();
        o_fail_count <= mismatch_count;
    end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top of the arena allocator: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import laa_pkg::*;

    localparam int OFFSET_W     = DEF_OFFSET_BITS;
    localparam int ALIGN_W      = DEF_ALIGN_BITS;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 60;
    localparam int HOLD_CYCLES  = 300;
    localparam int HISTORY      = 8;
    // Registers sit at eight-byte steps, the select being the doubleword bit.
    localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_BASE = {REG_BASE, 3'b000};
    localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_CAP  = {REG_CAP, 3'b000};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fail_count;
    int                    pending;

    // Shared between the sender and the receiver.
    bit                    no_idle = 1'b0;
    bit                    hold_rsp_req = 1'b0;
    logic [OFFSET_W-1:0]   seen_cursor = '0;
    logic [ADDR_W-1:0]     seen_addr = '0;
    logic [ADDR_W-1:0]     addr_hist[HISTORY];
    int                    hist_idx = 0;
    logic [ADDR_W-1:0]     cur_base = '0;
    logic [SIZE_W-1:0]     cur_cap = '0;

    laa_req_if #(.ALIGN_BITS(ALIGN_W))   req_bus ();
    laa_rsp_if #(.OFFSET_BITS(OFFSET_W)) rsp_bus ();

    linear_arena_allocator_top #(
        .OFFSET_BITS(OFFSET_W),
        .ALIGN_BITS (ALIGN_W)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus),
        .o_rsp  (rsp_bus),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    laa_response_check alloc_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .req_mon     (req_bus),
        .rsp_mon     (rsp_bus),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Overall watchdog on the run.
    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: random stalls, one long hold-off on request, and a record of results.
    initial begin
        int stall;
        rsp_bus.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_rsp_req) begin
                hold_rsp_req = 1'b0;
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_bus.valid);
            seen_cursor = rsp_bus.cursor_now;
            if (rsp_bus.ok && rsp_bus.new_address != '0) begin
                seen_addr          = rsp_bus.new_address;
                addr_hist[hist_idx] = rsp_bus.new_address;
                hist_idx           = (hist_idx + 1) % HISTORY;
            end
        end
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        return {16'($urandom()), 32'($urandom())};
    endfunction

    // Mostly small sizes, now and then large or full-width ones.
    function automatic logic [SIZE_W-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return $urandom();
        end else if (r == 1) begin
            return $urandom_range(0, 65535);
        end
        return $urandom_range(1, 256);
    endfunction

    // Mostly small powers of two, sometimes large ones or any value at all.
    function automatic logic [ALIGN_W-1:0] pick_align();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 9) begin
            return ALIGN_W'($urandom());
        end else if (r == 8) begin
            return ALIGN_W'(1) << $urandom_range(7, ALIGN_W - 1);
        end
        return ALIGN_W'(1) << $urandom_range(0, 6);
    endfunction

    // Offers one request and returns at the edge of its transfer.
    task automatic send_request(input t_action act, input logic [ADDR_W-1:0] old_addr,
                                input logic [SIZE_W-1:0] old_size,
                                input logic [SIZE_W-1:0] new_size,
                                input logic [ALIGN_W-1:0] align,
                                input logic [SIZE_W-1:0] mark);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.action      <= act;
        req_bus.old_address <= old_addr;
        req_bus.old_size    <= old_size;
        req_bus.new_size    <= new_size;
        req_bus.alignment   <= align;
        req_bus.mark        <= mark;
        do @(posedge i_clk); while (!req_bus.ready);
    endtask

    // Stops offering and waits until every response has been taken.
    task automatic drain();
        req_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] cap);
        drain();
        apb_write(CFG_ADDR_BASE, CFG_DATA_W'(base));
        apb_write(CFG_ADDR_CAP, CFG_DATA_W'(cap));
        cur_base = base;
        cur_cap  = cap;
    endtask

    // Fixed cases with an unaligned base of 0x1003 and 64 KiB of capacity.
    task automatic run_directed();
        logic [ADDR_W-1:0] last_addr;
        send_request(ACT_READ, '0, '0, '0, 17'd1, '0);
        send_request(ACT_REALLOC, '0, '0, 32'd100, 17'd16, '0);
        // Zero alignment behaves as alignment one.
        send_request(ACT_REALLOC, '0, '0, 32'd7, 17'd0, '0);
        send_request(ACT_REALLOC, '0, '0, 32'd1, 17'h10000, '0);
        send_request(ACT_REALLOC, '0, '0, 32'hFFFF_FFFF, 17'd1, '0);
        // Rewind above the limit is refused, rewind to the limit itself is not.
        send_request(ACT_REWIND, '0, '0, '0, 17'd1, 32'hFFFF_FFFF);
        send_request(ACT_REWIND, '0, '0, '0, 17'd1, cur_cap);
        send_request(ACT_FREE_ALL, '0, '0, '0, 17'd1, '0);
        // Shrink, grow and free the most recent block in place.
        send_request(ACT_REWIND, '0, '0, '0, 17'd1, 32'd64);
        last_addr = cur_base + 48'd32;
        send_request(ACT_REALLOC, last_addr, 32'd32, 32'd16, 17'd1, '0);
        send_request(ACT_REALLOC, last_addr, 32'd16, 32'd48, 17'd1, '0);
        send_request(ACT_REALLOC, last_addr, 32'd48, 32'd0, 17'd1, '0);
        // Freeing a block that is not the last one leaves the cursor alone.
        send_request(ACT_REALLOC, 48'h2000, 32'd8, 32'd0, 17'd1, '0);
        // A misaligned old block is moved and copied.
        send_request(ACT_REALLOC, last_addr, 32'd8, 32'd16, 17'd4, '0);
        send_request(ACT_REALLOC, 48'h4000, 32'd64, 32'd32, 17'd1, '0);
        send_request(ACT_REALLOC, 48'h4000, 32'd16, 32'd64, 17'd8, '0);
        // A size with a null address still counts as an existing block.
        send_request(ACT_REALLOC, '0, 32'd10, 32'd20, 17'd1, '0);
        // Reclaiming more than the cursor holds clamps it to zero.
        send_request(ACT_REWIND, '0, '0, '0, 17'd1, 32'd16);
        send_request(ACT_REALLOC, cur_base + 48'd16 - 48'd1000, 32'd1000, 32'd0, 17'd1, '0);
        send_request(ACT_REWIND, '0, '0, '0, 17'd1, '0);
        send_request(ACT_REALLOC, '1, '1, '1, '1, '1);
        send_request(ACT_READ, '1, '1, '1, '1, '1);
    endtask

    // Random part: mostly chains on real blocks, the rest noise.
    task automatic run_random(input int count, input bit with_hold, input bit with_burst);
        int unsigned       kind;
        logic [ADDR_W-1:0] old_addr;
        logic [ADDR_W-1:0] span;
        logic [SIZE_W-1:0] old_size;
        logic [SIZE_W-1:0] new_size;
        logic [SIZE_W-1:0] mark;
        for (int i = 0; i < count; i++) begin
            if (with_hold && i == count / 3) begin
                hold_rsp_req = 1'b1;
            end
            no_idle = with_burst && (i >= count / 2) && (i < count / 2 + 40);
            kind = $urandom_range(0, 99);
            if (kind < 30 || (kind < 55 && seen_addr == '0)) begin
                old_addr = ($urandom_range(0, 3) == 0) ? rand_addr() : '0;
                send_request(ACT_REALLOC, old_addr, '0, pick_size(), pick_align(), $urandom());
            end else if (kind < 55) begin
                // Work on the most recent block, once its address is known.
                drain();
                span     = cur_base + ADDR_W'(seen_cursor) - seen_addr;
                old_size = span[SIZE_W-1:0];
                case ($urandom_range(0, 2))
                    0: new_size = '0;
                    1: new_size = $urandom_range(0, old_size);
                    default: new_size = old_size + pick_size();
                endcase
                send_request(ACT_REALLOC, seen_addr, old_size, new_size, pick_align(),
                             $urandom());
            end else if (kind < 70) begin
                old_addr = addr_hist[$urandom_range(0, HISTORY - 1)];
                send_request(ACT_REALLOC, old_addr, pick_size(), pick_size(), pick_align(),
                             $urandom());
            end else if (kind < 80) begin
                case ($urandom_range(0, 3))
                    0: mark = $urandom_range(0, seen_cursor);
                    1: mark = cur_cap;
                    2: mark = cur_cap + 32'd1;
                    default: mark = $urandom();
                endcase
                send_request(ACT_REWIND, rand_addr(), $urandom(), $urandom(), pick_align(),
                             mark);
            end else if (kind < 85) begin
                send_request(ACT_FREE_ALL, rand_addr(), $urandom(), $urandom(), pick_align(),
                             $urandom());
            end else if (kind < 90) begin
                send_request(ACT_READ, rand_addr(), $urandom(), $urandom(), pick_align(),
                             $urandom());
            end else begin
                send_request(t_action'($urandom_range(0, 3)), rand_addr(), $urandom(),
                             $urandom(), ALIGN_W'($urandom()), $urandom());
            end
        end
        no_idle = 1'b0;
    endtask

    // Reset, then the phases of register settings with their stimulus, then the verdict.
    initial begin
        int drain_cycles;
        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        req_bus.valid       <= 1'b0;
        req_bus.action      <= ACT_READ;
        req_bus.old_address <= '0;
        req_bus.old_size    <= '0;
        req_bus.new_size    <= '0;
        req_bus.alignment   <= 17'd1;
        req_bus.mark        <= '0;
        for (int i = 0; i < HISTORY; i++) begin
            addr_hist[i] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        configure(48'h0000_0000_1003, 32'h0001_0000);
        run_directed();
        run_random(400, 1'b0, 1'b0);

        // A block at address zero comes back as a null address with success.
        configure(48'h0, 32'h0000_0100);
        send_request(ACT_FREE_ALL, '0, '0, '0, 17'd1, '0);
        send_request(ACT_REALLOC, '0, '0, 32'd16, 17'd1, '0);
        run_random(150, 1'b0, 1'b0);

        configure(48'hFFFF_FFFF_FF00, 32'hFFFF_FFFF);
        run_random(400, 1'b1, 1'b0);

        configure(48'hFFFF_FFFF_FFFF, 32'h0);
        run_random(50, 1'b0, 1'b0);

        configure(rand_addr(), $urandom_range(4096, 1 << 20));
        run_random(350, 1'b0, 1'b1);

        configure(48'h7FFF_0000_0001, 32'h0000_2000);
        run_random(400, 1'b1, 1'b1);

        req_bus.valid <= 1'b0;
        drain_cycles = 0;
        do begin
            @(posedge i_clk);
            drain_cycles++;
        end while (pending != 0 && drain_cycles < DRAIN_LIMIT);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/laa_pkg.sv
rtl/laa_ifs.sv
rtl/laa_regs.sv
rtl/laa_rem.sv
rtl/laa_dp.sv
rtl/laa_ctrl.sv
rtl/linear_arena_allocator_top.sv
rtl/laa_checker.sv
tb/sv/laa_response_check.sv
tb/sv/tb.sv
